// ===== src/gpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_pkg
// Shared types, constants and helpers of the grid plane tessellator.
// ----------------------------------------------------------------------------
package gpt_pkg;

  localparam int COUNT_W   = 11;
  localparam int COORD_W   = 10;
  localparam int LEN_W     = 20;
  localparam int POS_W     = 21;
  localparam int TEX_W     = 17;
  localparam int INDEX_W   = 20;
  localparam int NUM_W     = 30;
  localparam int MAX_DIV   = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W    = 2;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_QUAD   = 1'b1;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_WIDTH   = 2'd2;
  localparam logic [1:0] REG_DEPTH   = 2'd3;

  typedef struct packed {
    logic                 op;
    logic                 err;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [INDEX_W-1:0]   base;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cols;
    logic [COUNT_W-1:0] rows;
    logic [LEN_W-1:0]   width;
    logic [LEN_W-1:0]   depth;
  } cfg_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] r;
    r = n;
    if (n < COUNT_W'(2)) r = COUNT_W'(2);
    else if (n > COUNT_W'(MAX_DIV)) r = COUNT_W'(MAX_DIV);
    return r;
  endfunction

endpackage

// ===== src/gpt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_front
// Accept requests, check them against the grid and form the base index.
// ----------------------------------------------------------------------------
module gpt_front (
  input  gpt_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [gpt_pkg::COORD_W-1:0]    in_col,
  input  logic [gpt_pkg::COORD_W-1:0]    in_row,
  output logic                           push,
  output gpt_pkg::entry_t                push_data,
  input  logic                           q_full
);
  import gpt_pkg::*;

  logic [COUNT_W-1:0] lim_c;
  logic [COUNT_W-1:0] lim_r;
  logic [COUNT_W+COORD_W-1:0] prod;

  always_comb begin
    if (in_op == OP_QUAD) begin
      lim_c = cfg.cols - COUNT_W'(1);
      lim_r = cfg.rows - COUNT_W'(1);
    end else begin
      lim_c = cfg.cols;
      lim_r = cfg.rows;
    end
  end

  assign prod = in_row * cfg.cols;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.op   = in_op;
    push_data.err  = ({1'b0, in_col} >= lim_c) || ({1'b0, in_row} >= lim_r);
    push_data.col  = in_col;
    push_data.row  = in_row;
    push_data.base = INDEX_W'(prod + (COUNT_W + COORD_W)'(in_col));
  end

endmodule

// ===== src/gpt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module gpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpt_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output gpt_pkg::entry_t pop_data
);
  import gpt_pkg::*;

  entry_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QPTR_W:0]    count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign q_valid  = count != '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

// ===== src/gpt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpt_back
// Divide out vertex attributes or walk quad indices and drive results.
// ----------------------------------------------------------------------------
module gpt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  gpt_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  gpt_pkg::entry_t                q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gpt_pkg::POS_W-1:0]      pos_x,
  output logic [gpt_pkg::POS_W-1:0]      pos_z,
  output logic [gpt_pkg::TEX_W-1:0]      tex_u,
  output logic [gpt_pkg::TEX_W-1:0]      tex_v,
  output logic [gpt_pkg::INDEX_W-1:0]    index,
  output logic                           last,
  output logic                           range_error
);
  import gpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state;
  entry_t              ent;
  logic [4:0]          step;
  logic [2:0]          k;
  logic [NUM_W-1:0]    numq [4];
  logic [COORD_W-1:0]  rem  [4];
  logic [COORD_W-1:0]  dvs  [4];
  logic [NUM_W-1:0]    numq_next [4];
  logic [COORD_W-1:0]  rem_next  [4];
  logic                load;
  logic [INDEX_W-1:0]  quad_idx;

  assign dvs[0] = COORD_W'(cfg.cols - COUNT_W'(1));
  assign dvs[1] = COORD_W'(cfg.rows - COUNT_W'(1));
  assign dvs[2] = COORD_W'(cfg.cols - COUNT_W'(1));
  assign dvs[3] = COORD_W'(cfg.rows - COUNT_W'(1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [COORD_W:0] t;
      t = {rem[i], numq[i][NUM_W-1]};
      if (t >= {1'b0, dvs[i]}) begin
        rem_next[i]  = COORD_W'(t - {1'b0, dvs[i]});
        numq_next[i] = {numq[i][NUM_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = COORD_W'(t);
        numq_next[i] = {numq[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    quad_idx = ent.base;
    if (k == 3'd2 || k == 3'd3 || k == 3'd5) quad_idx = quad_idx + INDEX_W'(cfg.cols);
    if (k == 3'd1 || k == 3'd4 || k == 3'd5) quad_idx = quad_idx + INDEX_W'(1);
  end

  assign pop  = (state == ST_IDLE) && q_valid;
  assign load = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      ent     <= q_data;
      numq[0] <= NUM_W'(q_data.col) * NUM_W'(cfg.width);
      numq[1] <= NUM_W'(q_data.row) * NUM_W'(cfg.depth);
      numq[2] <= NUM_W'({q_data.col, 16'b0});
      numq[3] <= NUM_W'({q_data.row, 16'b0});
      for (int i = 0; i < 4; i++) rem[i] <= '0;
    end else if (state == ST_DIV) begin
      for (int i = 0; i < 4; i++) begin
        numq[i] <= numq_next[i];
        rem[i]  <= rem_next[i];
      end
    end
    if (load) begin
      pos_x       <= '0;
      pos_z       <= '0;
      tex_u       <= '0;
      tex_v       <= '0;
      index       <= '0;
      last        <= 1'b1;
      range_error <= ent.err;
      if (!ent.err) begin
        if (ent.op == OP_QUAD) begin
          index <= quad_idx;
          last  <= k == 3'd5;
        end else begin
          pos_x <= POS_W'(numq[0]) - POS_W'(cfg.width >> 1);
          pos_z <= POS_W'(cfg.depth >> 1) - POS_W'(numq[1]);
          tex_u <= TEX_W'(numq[2]);
          tex_v <= TEX_W'(numq[3]);
          index <= ent.base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            step <= '0;
            k    <= '0;
            if (q_data.err || q_data.op == OP_QUAD) state <= ST_EMIT;
            else state <= ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 5'd1;
          if (step == 5'(NUM_W - 1)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            if (ent.err || ent.op == OP_VERTEX || k == 3'd5) begin
              state <= ST_IDLE;
              k     <= '0;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && range_error |-> last)
    else $error("error result without last");
  assert property (@(posedge clk) disable iff (rst) k <= 3'd5)
    else $error("quad counter overrun");
  assert property (@(posedge clk) disable iff (rst) pop |=> state != ST_IDLE)
    else $error("request popped but not started");

endmodule

// ===== src/grid_plane_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_plane_tessellator
// Flat XZ grid plane: vertex attributes and quad triangle indices.
// ----------------------------------------------------------------------------
// Requests are checked and indexed on entry and held in a four-deep queue, so
// the input keeps accepting while results drain. A quad request gives six
// index results, one per cycle while the output is not stalled. A vertex
// request runs four parallel restoring dividers that retire one quotient bit
// per cycle over the 30-bit numerators. An out-of-grid request gives one
// error result. Registers are at byte addresses 0, 4, 8 and 12 and should
// only be written while no request is pending.
module grid_plane_tessellator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // column[9:0], row[19:10], zero pad
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // position_x, position_z, tex_u, tex_v, vertex_index
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // range_error
);
  import gpt_pkg::*;

  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;
  logic [LEN_W-1:0]   width_length;
  logic [LEN_W-1:0]   depth_length;
  cfg_t               cfg;
  logic               push;
  entry_t             push_data;
  logic               q_full;
  logic               pop;
  logic               q_valid;
  entry_t             q_data;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_z;
  logic [TEX_W-1:0]   tex_u;
  logic [TEX_W-1:0]   tex_v;
  logic [INDEX_W-1:0] index;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COUNT_W'(2);
      row_count    <= COUNT_W'(2);
      width_length <= LEN_W'(256);
      depth_length <= LEN_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_COLUMNS: column_count <= pwdata[COUNT_W-1:0];
        REG_ROWS:    row_count    <= pwdata[COUNT_W-1:0];
        REG_WIDTH:   width_length <= pwdata[LEN_W-1:0];
        REG_DEPTH:   depth_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLUMNS: prdata = 32'(column_count);
      REG_ROWS:    prdata = 32'(row_count);
      REG_WIDTH:   prdata = 32'(width_length);
      REG_DEPTH:   prdata = 32'(depth_length);
      default:     prdata = '0;
    endcase
  end

  assign cfg.cols  = clamp_count(column_count);
  assign cfg.rows  = clamp_count(row_count);
  assign cfg.width = width_length;
  assign cfg.depth = depth_length;

  gpt_front u_front (
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_col    (s_axis_tdata[9:0]),
    .in_row    (s_axis_tdata[19:10]),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  gpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (q_data)
  );

  gpt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pos_x       (pos_x),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .index       (index),
    .last        (m_axis_tlast),
    .range_error (m_axis_tuser)
  );

  assign m_axis_tdata = {index, tex_v, tex_u, pos_z, pos_x};

endmodule

// ===== sim/tb_grid_plane_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_plane_tessellator
// Self-checking bench for the grid plane tessellator: directed corner
// requests, then random vertex and quad requests over several grid settings,
// with random idling on both streams and a field-by-field result check.
// ----------------------------------------------------------------------------
module tb_grid_plane_tessellator;
  import gpt_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] pz;
    logic [TEX_W-1:0]        u;
    logic [TEX_W-1:0]        v;
    logic [INDEX_W-1:0]      idx;
    logic                    last;
    logic                    err;
  } vtx_t;

  class mesh_scoreboard;
    vtx_t pending[$];
    int errors = 0;
    int vertex_reqs = 0;
    int quad_reqs = 0;
    int bad_reqs = 0;
    int checked = 0;
    logic [COUNT_W-1:0] cols_reg = 2, rows_reg = 2;
    logic [LEN_W-1:0] width_reg = 256, depth_reg = 256;

    function automatic vtx_t blank();
      vtx_t r;
      r.px = 0; r.pz = 0; r.u = 0; r.v = 0; r.idx = 0; r.last = 0; r.err = 0;
      return r;
    endfunction

    function void add_expected(vtx_t e);
      pending.insert(pending.size(), e);
    endfunction

    function void note_request(logic op, logic [9:0] col, logic [9:0] row);
      longint c, r, a;
      vtx_t e;
      c = cols_reg < 2 ? 2 : (cols_reg > MAX_DIV ? MAX_DIV : cols_reg);
      r = rows_reg < 2 ? 2 : (rows_reg > MAX_DIV ? MAX_DIV : rows_reg);
      e = blank();
      if (op == OP_VERTEX) begin
        if (col >= c || row >= r) begin
          e.last = 1; e.err = 1; bad_reqs++;
        end else begin
          e.px = POS_W'((longint'(col) * width_reg) / (c - 1) - (width_reg >> 1));
          e.pz = POS_W'((depth_reg >> 1) - (longint'(row) * depth_reg) / (r - 1));
          e.u = TEX_W'((longint'(col) * 65536) / (c - 1));
          e.v = TEX_W'((longint'(row) * 65536) / (r - 1));
          e.idx = INDEX_W'(row * c + col);
          e.last = 1;
          vertex_reqs++;
        end
        add_expected(e);
      end else if (col >= c - 1 || row >= r - 1) begin
        e.last = 1; e.err = 1; bad_reqs++;
        add_expected(e);
      end else begin
        a = row * c + col;
        quad_reqs++;
        e.idx = INDEX_W'(a);         add_expected(e);
        e.idx = INDEX_W'(a + 1);     add_expected(e);
        e.idx = INDEX_W'(a + c);     add_expected(e);
        add_expected(e);
        e.idx = INDEX_W'(a + 1);     add_expected(e);
        e.idx = INDEX_W'(a + c + 1); e.last = 1; add_expected(e);
      end
    endfunction

    function void check_result(vtx_t got);
      vtx_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result idx=%0d err=%0b", $time, got.idx, got.err);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.px !== e.px || got.pz !== e.pz || got.u !== e.u || got.v !== e.v ||
          got.idx !== e.idx || got.last !== e.last || got.err !== e.err) begin
        $display("%0t mismatch exp x=%0d z=%0d u=%0d v=%0d i=%0d l=%0b e=%0b",
                 $time, e.px, e.pz, e.u, e.v, e.idx, e.last, e.err);
        $display("%0t          got x=%0d z=%0d u=%0d v=%0d i=%0d l=%0b e=%0b",
                 $time, got.px, got.pz, got.u, got.v, got.idx, got.last, got.err);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [23:0] s_axis_tdata = 0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic m_axis_tlast, m_axis_tuser;

  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;
  mesh_scoreboard sb = new();

  grid_plane_tessellator u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    vtx_t got;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[20:0];
      got.pz = m_axis_tdata[41:21];
      got.u = m_axis_tdata[58:42];
      got.v = m_axis_tdata[75:59];
      got.idx = m_axis_tdata[95:76];
      got.last = m_axis_tlast;
      got.err = m_axis_tuser;
      sb.check_result(got);
    end
  end

  always @(negedge clk)
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk);
    case (idx)
      REG_COLUMNS: sb.cols_reg = val[COUNT_W-1:0];
      REG_ROWS:    sb.rows_reg = val[COUNT_W-1:0];
      REG_WIDTH:   sb.width_reg = val[LEN_W-1:0];
      default:     sb.depth_reg = val[LEN_W-1:0];
    endcase
  endtask

  task automatic send_request(logic op, logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= {4'b0, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, col, row);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(int c, int r, int w, int d);
    write_reg(REG_COLUMNS, c);
    write_reg(REG_ROWS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_DEPTH, d);
  endtask

  task automatic random_phase(int n);
    logic [9:0] c, r;
    int cl, rl;
    cl = sb.cols_reg < 2 ? 2 : (sb.cols_reg > MAX_DIV ? MAX_DIV : sb.cols_reg);
    rl = sb.rows_reg < 2 ? 2 : (sb.rows_reg > MAX_DIV ? MAX_DIV : sb.rows_reg);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        c = 10'($urandom); r = 10'($urandom);
      end else begin
        c = 10'($urandom_range(cl - 1)); r = 10'($urandom_range(rl - 1));
      end
      send_request(1'($urandom_range(1)), c, r);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // reset grid, then corners of a large grid
    send_request(OP_VERTEX, 0, 0);
    send_request(OP_VERTEX, 1, 1);
    send_request(OP_QUAD, 0, 0);
    send_request(OP_QUAD, 1, 0);
    send_request(OP_VERTEX, 2, 0);
    drain();
    configure(1024, 1024, 20'hFFFFF, 20'hFFFFF);
    send_request(OP_VERTEX, 0, 0);
    send_request(OP_VERTEX, 1023, 1023);
    send_request(OP_VERTEX, 512, 341);
    send_request(OP_QUAD, 1022, 1022);
    send_request(OP_QUAD, 1023, 0);
    send_request(OP_QUAD, 0, 1023);
    send_request(OP_VERTEX, 10'h3FF, 10'h155);
    drain();
    configure(0, 2047, 0, 1);
    send_request(OP_VERTEX, 1, 1);
    send_request(OP_QUAD, 0, 0);
    send_request(OP_VERTEX, 1023, 0);
    drain();
    configure(5, 3, 1000, 777);
    send_request(OP_VERTEX, 4, 2);
    send_request(OP_VERTEX, 5, 0);
    send_request(OP_QUAD, 3, 1);
    send_request(OP_QUAD, 4, 1);
    drain();

    send_idle = 0; recv_stall = 0;
    configure(17, 9, 5000, 123457);
    random_phase(33);
    drain();
    send_idle = 50; recv_stall = 0;
    configure(1024, 1024, 20'hFFFFF, 20'hFFFFF);
    random_phase(33);
    drain();
    send_idle = 0; recv_stall = 50;
    configure(3, 700, 31, 999999);
    random_phase(33);
    drain();
    send_idle = 7; recv_stall = 7;
    configure($urandom_range(2, 64), $urandom_range(2, 64), $urandom, $urandom);
    random_phase(33);
    drain();

    $display("covered %0d vertex, %0d quad and %0d out-of-grid requests", sb.vertex_reqs,
             sb.quad_reqs, sb.bad_reqs);
    $display("%0d results checked over seven grid settings", sb.checked);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
